// File: src/psar_pkg.sv
`timescale 1ns / 1ps
// Shared types, command codes and constants of the scroll address register unit.
// Has no dependencies; used by psar_palette and ppu_scroll_address_registers_unit.
package psar_pkg;

    // Command codes carried in the low nibble of an input item.
    typedef enum logic [3:0] {
        CMD_CTRL_WR   = 4'd0,
        CMD_MASK_WR   = 4'd1,
        CMD_STATUS_RD = 4'd2,
        CMD_SCROLL_WR = 4'd3,
        CMD_ADDR_WR   = 4'd4,
        CMD_DATA_WR   = 4'd5,
        CMD_DATA_RD   = 4'd6,
        CMD_INC_HORI  = 4'd7,
        CMD_INC_VERT  = 4'd8,
        CMD_COPY_HORI = 4'd9,
        CMD_COPY_VERT = 4'd10
    } psar_cmd_t;

    localparam int ADDR_W     = 15;
    localparam int MEM_ADDR_W = 14;
    localparam int PAL_IDX_W  = 5;

    // Field masks of the scroll address.
    localparam logic [ADDR_W-1:0] SCROLL_Y_MASK  = 15'h73E0;
    localparam logic [ADDR_W-1:0] HORI_KEEP_MASK = 15'h7BE0;
    localparam logic [ADDR_W-1:0] HORI_COPY_MASK = 15'h041F;
    localparam logic [ADDR_W-1:0] COARSE_Y_TEST  = 15'h03A0;
    localparam logic [MEM_ADDR_W-1:0] PALETTE_BASE = 14'h3F00;
    localparam logic [7:0] GREY_MASK = 8'h30;

    // Write request to the palette store.
    typedef struct packed {
        logic                 en;
        logic [PAL_IDX_W-1:0] idx;
        logic [7:0]           data;
    } pal_wr_t;

    // Palette index with the backdrop mirrors folded onto their base entries.
    function automatic logic [PAL_IDX_W-1:0] pal_index(input logic [MEM_ADDR_W-1:0] a);
        logic [PAL_IDX_W-1:0] i;
        i = a[PAL_IDX_W-1:0];
        if (i[4] && (i[1:0] == 2'b00))
        begin
            i[4] = 1'b0;
        end
        return i;
    endfunction

endpackage

// File: src/psar_palette.sv
`timescale 1ns / 1ps
// Palette store of the scroll address register unit: flip-flop array cleared at reset,
// one write port and one read port with the grey mask. Depends on psar_pkg.
module psar_palette #(
    parameter int PALETTE_DEPTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  psar_pkg::pal_wr_t              wr,
    input  logic [psar_pkg::PAL_IDX_W-1:0] rd_idx,
    input  logic                           grey,
    output logic [7:0]                     rd_data
);

    localparam int IDX_W = $clog2(PALETTE_DEPTH);

    logic [7:0] pal_reg [PALETTE_DEPTH];
    logic [7:0] entry;

    // Storage; every entry reads as zero after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < PALETTE_DEPTH; k++)
            begin
                pal_reg[k] <= '0;
            end
        end
        else if (wr.en)
        begin
            pal_reg[wr.idx[IDX_W-1:0]] <= wr.data;
        end
    end

    // Read with the grey mask applied.
    assign entry   = pal_reg[rd_idx[IDX_W-1:0]];
    assign rd_data = grey ? (entry & psar_pkg::GREY_MASK) : entry;

endmodule

// File: src/ppu_scroll_address_registers_unit.sv
`timescale 1ns / 1ps
// Scroll address register unit: top level. Depends on psar_pkg and psar_palette.
// Path: an accepted item is captured in the input register; its result is loaded into
// the result register when the item moves on, which waits while a result is not taken.
// Throughput: one item per cycle while m_tready stays high; state is updated as an item
// moves from the input register to the result register.
// Reset clears the valid flags, the state and all PALETTE_DEPTH palette entries at once.
module ppu_scroll_address_registers_unit #(
    parameter int PALETTE_DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // cmd[3:0], value[11:4], mem_data[19:12], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // read_value[7:0], mem_addr[21:8], mem_write[22],
                                   // current_addr[37:23], fine_scroll_x[40:38], zero pad
);

    localparam int AW = psar_pkg::ADDR_W;
    localparam int MW = psar_pkg::MEM_ADDR_W;

    // Input register.
    logic                in_valid_reg;
    psar_pkg::psar_cmd_t in_cmd_reg;
    logic [7:0]          in_value_reg;
    logic [7:0]          in_mdat_reg;

    // Architectural state.
    logic [AW-1:0] cur_addr_reg, cur_addr_next;
    logic [AW-1:0] temp_addr_reg, temp_addr_next;
    logic [2:0]    fine_x_reg, fine_x_next;
    logic          toggle_reg, toggle_next;
    logic [7:0]    ctrl_reg, ctrl_next;
    logic [7:0]    mask_reg, mask_next;
    logic [7:0]    rbuf_reg, rbuf_next;

    // Result register.
    logic          out_valid_reg;
    logic [7:0]    rd_val_reg, rd_val_next;
    logic [MW-1:0] maddr_reg, maddr_next;
    logic          mwr_reg, mwr_next;

    logic              advance;
    logic [MW-1:0]     data_addr;
    logic              is_palette;
    logic [AW-1:0]     step_addr;
    logic [AW-1:0]     vert_tmp;
    psar_pkg::pal_wr_t pal_wr;
    logic [7:0]        pal_rd;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register capture.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_cmd_reg   <= psar_pkg::psar_cmd_t'(s_tdata[3:0]);
            in_value_reg <= s_tdata[11:4];
            in_mdat_reg  <= s_tdata[19:12];
        end
    end

    // Shared decode of a data access.
    assign data_addr  = cur_addr_reg[MW-1:0];
    assign is_palette = (data_addr[MW-1:8] == psar_pkg::PALETTE_BASE[MW-1:8]);
    assign step_addr  = cur_addr_reg + (ctrl_reg[2] ? AW'(32) : AW'(1));

    psar_palette #(
        .PALETTE_DEPTH(PALETTE_DEPTH)
    ) u_palette (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (pal_wr),
        .rd_idx (psar_pkg::pal_index(data_addr)),
        .grey   (mask_reg[0]),
        .rd_data(pal_rd)
    );

    // Next state and result of the item held in the input register.
    always_comb
    begin
        cur_addr_next  = cur_addr_reg;
        temp_addr_next = temp_addr_reg;
        fine_x_next    = fine_x_reg;
        toggle_next    = toggle_reg;
        ctrl_next      = ctrl_reg;
        mask_next      = mask_reg;
        rbuf_next      = rbuf_reg;
        rd_val_next    = '0;
        mwr_next       = 1'b0;
        vert_tmp       = cur_addr_reg;
        pal_wr.en      = 1'b0;
        pal_wr.idx     = psar_pkg::pal_index(data_addr);
        pal_wr.data    = in_value_reg;

        case (in_cmd_reg)
            psar_pkg::CMD_CTRL_WR:
            begin
                ctrl_next             = in_value_reg;
                temp_addr_next[11:10] = in_value_reg[1:0];
            end
            psar_pkg::CMD_MASK_WR:
            begin
                mask_next = in_value_reg;
            end
            psar_pkg::CMD_STATUS_RD:
            begin
                toggle_next = 1'b0;
            end
            psar_pkg::CMD_SCROLL_WR:
            begin
                toggle_next = !toggle_reg;
                if (!toggle_reg)
                begin
                    temp_addr_next[4:0] = in_value_reg[7:3];
                    fine_x_next         = in_value_reg[2:0];
                end
                else
                begin
                    temp_addr_next        = temp_addr_reg & ~psar_pkg::SCROLL_Y_MASK;
                    temp_addr_next[9:5]   = in_value_reg[7:3];
                    temp_addr_next[14:12] = in_value_reg[2:0];
                end
            end
            psar_pkg::CMD_ADDR_WR:
            begin
                toggle_next = !toggle_reg;
                if (!toggle_reg)
                begin
                    temp_addr_next[14]   = 1'b0;
                    temp_addr_next[13:8] = in_value_reg[5:0];
                end
                else
                begin
                    temp_addr_next[7:0] = in_value_reg;
                    cur_addr_next       = {temp_addr_reg[14:8], in_value_reg};
                end
            end
            psar_pkg::CMD_DATA_WR:
            begin
                mwr_next      = !is_palette;
                pal_wr.en     = is_palette;
                cur_addr_next = step_addr;
            end
            psar_pkg::CMD_DATA_RD:
            begin
                rd_val_next   = is_palette ? pal_rd : rbuf_reg;
                rbuf_next     = in_mdat_reg;
                cur_addr_next = step_addr;
            end
            psar_pkg::CMD_INC_HORI:
            begin
                if (cur_addr_reg[4:0] == 5'd31)
                begin
                    cur_addr_next      = cur_addr_reg;
                    cur_addr_next[4:0] = 5'd0;
                    cur_addr_next[10]  = !cur_addr_reg[10];
                end
                else
                begin
                    cur_addr_next = cur_addr_reg + AW'(1);
                end
            end
            psar_pkg::CMD_INC_VERT:
            begin
                if (cur_addr_reg[14:12] == 3'd7)
                begin
                    vert_tmp[14:12] = 3'd0;
                    if ((vert_tmp & psar_pkg::COARSE_Y_TEST) == psar_pkg::COARSE_Y_TEST)
                    begin
                        // Coarse Y at 29 flips the vertical table; 29 and 31 wrap to 0.
                        if (!vert_tmp[6])
                        begin
                            vert_tmp[11] = !vert_tmp[11];
                        end
                        vert_tmp[9:5] = 5'd0;
                        cur_addr_next = vert_tmp;
                    end
                    else
                    begin
                        cur_addr_next = vert_tmp + AW'(32);
                    end
                end
                else
                begin
                    cur_addr_next = cur_addr_reg + AW'(16'h1000);
                end
            end
            psar_pkg::CMD_COPY_HORI:
            begin
                cur_addr_next = (cur_addr_reg & psar_pkg::HORI_KEEP_MASK)
                              | (temp_addr_reg & psar_pkg::HORI_COPY_MASK);
            end
            psar_pkg::CMD_COPY_VERT:
            begin
                cur_addr_next = (cur_addr_reg & psar_pkg::HORI_COPY_MASK)
                              | (temp_addr_reg & psar_pkg::HORI_KEEP_MASK);
            end
            default:
            begin
            end
        endcase

        // Data accesses report the address before the step.
        if (in_cmd_reg == psar_pkg::CMD_DATA_WR || in_cmd_reg == psar_pkg::CMD_DATA_RD)
        begin
            maddr_next = data_addr;
        end
        else
        begin
            maddr_next = cur_addr_next[MW-1:0];
        end

        if (!advance)
        begin
            pal_wr.en = 1'b0;
        end
    end

    // State update, taken only when the item moves on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_addr_reg  <= '0;
            temp_addr_reg <= '0;
            fine_x_reg    <= '0;
            toggle_reg    <= 1'b0;
            ctrl_reg      <= '0;
            mask_reg      <= '0;
            rbuf_reg      <= '0;
        end
        else if (advance)
        begin
            cur_addr_reg  <= cur_addr_next;
            temp_addr_reg <= temp_addr_next;
            fine_x_reg    <= fine_x_next;
            toggle_reg    <= toggle_next;
            ctrl_reg      <= ctrl_next;
            mask_reg      <= mask_next;
            rbuf_reg      <= rbuf_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rd_val_reg <= rd_val_next;
            maddr_reg  <= maddr_next;
            mwr_reg    <= mwr_next;
        end
    end

    // The current address and fine X of a waiting result are the live state, which
    // cannot move on until that result is taken.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, fine_x_reg, cur_addr_reg, mwr_reg, maddr_reg, rd_val_reg};

    // Checks.
    a_mem_write_below_palette: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && mwr_reg) |-> (maddr_reg[MW-1:8] != psar_pkg::PALETTE_BASE[MW-1:8]))
        else $error("external write reported inside the palette range");

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> in_valid_reg)
        else $error("input stalled while the input register is empty");

    a_advance_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> m_tvalid)
        else $error("result lost after the item moved on");

    a_fine_x_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(advance) |-> $stable(fine_x_reg))
        else $error("fine X changed without an item moving on");

endmodule
